>>> hw/rtl/poisson_five_point_residual_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the five-point residual block
// Shared property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef POISSON_FIVE_POINT_RESIDUAL_MACROS_SVH
`define POISSON_FIVE_POINT_RESIDUAL_MACROS_SVH

// same-cycle implication, off during reset
`define P5R_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("p5r assertion failed");

// next-cycle implication, off during reset
`define P5R_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("p5r assertion failed");

// next-cycle implication, always live
`define P5R_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("p5r assertion failed");

`endif

>>> hw/rtl/p5r_pkg.sv
// ----------------------------------------------------------------------------
// p5r_pkg
// Types and constants of the five-point Laplacian residual block.
// ----------------------------------------------------------------------------
package p5r_pkg;

   localparam int VALUE_W    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_W     = 32;
   localparam int COEF_FRAC  = 12;
   localparam int COEF_HALF  = 16;
   localparam int IDX_W      = 11;
   localparam int MAX_PANELS = 1024;
   localparam int CSR_IDX_W  = 2;
   localparam int FIFO_DEPTH = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_PANELS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_PANELS = 2'd3;

   localparam logic [COEF_W-1:0] COEF_RESET   = '0;
   localparam logic [IDX_W-1:0]  PANELS_RESET = 11'd40;
   localparam logic [IDX_W-1:0]  PANELS_MIN   = 11'd2;

   typedef struct packed {
      logic             has_above;   // a residual of the row above is due
      logic             interior;
      logic             has_own;     // last row: own zero residual is due
      logic             own_last;
      logic [IDX_W-1:0] x_index;
      logic [IDX_W-1:0] y_above;
      logic [IDX_W-1:0] y_cur;
   } meta_type;

   typedef struct packed {
      meta_type                  meta;
      logic signed [VALUE_W-1:0] u_value;
      logic signed [VALUE_W-1:0] f_above;
      logic signed [VALUE_W-1:0] center;
      logic signed [VALUE_W-1:0] right;
      logic signed [VALUE_W-1:0] up2;
   } work_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] residual;
      logic [IDX_W-1:0]          x_index;
      logic [IDX_W-1:0]          y_index;
      logic                      saturated;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic    first;
      logic    second;
      rsp_type entry0;
      rsp_type entry1;
   } push_type;

endpackage

>>> hw/rtl/p5r_if.sv
// ----------------------------------------------------------------------------
// p5r channel interfaces
// Valid/ready channels for grid points in and residuals out.
// ----------------------------------------------------------------------------
interface p5r_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [p5r_pkg::VALUE_W-1:0] u_value;
   logic signed [p5r_pkg::VALUE_W-1:0] f_value;
   modport source (output valid, u_value, f_value, input ready);
   modport sink   (input valid, u_value, f_value, output ready);
endinterface

interface p5r_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [p5r_pkg::VALUE_W-1:0] residual;
   logic [p5r_pkg::IDX_W-1:0]          x_index;
   logic [p5r_pkg::IDX_W-1:0]          y_index;
   logic                               saturated;
   logic                               last;
   modport source (output valid, residual, x_index, y_index, saturated, last,
                   input ready);
   modport sink   (input valid, residual, x_index, y_index, saturated, last,
                   output ready);
endinterface

>>> hw/rtl/p5r_front.sv
// ----------------------------------------------------------------------------
// p5r_front
// Raster counters, point classification and the three line buffers.
// ----------------------------------------------------------------------------
module p5r_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic signed [p5r_pkg::VALUE_W-1:0] u_value,
   input  logic signed [p5r_pkg::VALUE_W-1:0] f_value,
   input  logic [p5r_pkg::IDX_W-1:0]          x_panels,
   input  logic [p5r_pkg::IDX_W-1:0]          y_panels,
   output logic [1:0]                         n_results,
   output logic                               work_valid,
   output p5r_pkg::work_type                  work
);
   localparam int DEPTH = p5r_pkg::MAX_PANELS + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [p5r_pkg::IDX_W-1:0] MAXP = p5r_pkg::IDX_W'(p5r_pkg::MAX_PANELS);

   logic [p5r_pkg::IDX_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [p5r_pkg::IDX_W-1:0] xp, yp, col_idx, row_above;
   logic                      has_above, interior, has_own, own_last;
   logic [AW-1:0]             addr, addr_right;

   logic signed [p5r_pkg::VALUE_W-1:0] u_above_mem [DEPTH];
   logic signed [p5r_pkg::VALUE_W-1:0] u_two_mem   [DEPTH];
   logic signed [p5r_pkg::VALUE_W-1:0] f_above_mem [DEPTH];

   logic signed [p5r_pkg::VALUE_W-1:0] center_ff, right_ff, up2_ff, f_ff, u_ff;
   p5r_pkg::meta_type                  meta_ff;
   logic [AW-1:0]                      wb_addr_ff;
   logic                               valid_ff;

   always_comb begin
      priority if (x_panels < p5r_pkg::PANELS_MIN) xp = p5r_pkg::PANELS_MIN;
      else if (x_panels > MAXP)                    xp = MAXP;
      else                                         xp = x_panels;
      priority if (y_panels < p5r_pkg::PANELS_MIN) yp = p5r_pkg::PANELS_MIN;
      else if (y_panels > MAXP)                    yp = MAXP;
      else                                         yp = y_panels;
      col_idx   = (col_ff > MAXP) ? MAXP : col_ff;
      row_above = row_ff - p5r_pkg::IDX_W'(1);
      has_above = (row_ff != '0);
      interior  = has_above && (row_above != '0) && (row_above < yp)
                  && (col_idx != '0) && (col_idx < xp);
      has_own   = (row_ff >= yp);
      own_last  = (col_idx >= xp);
      n_results = {1'b0, has_above} + {1'b0, has_own};
      addr       = AW'(col_idx);
      addr_right = addr + AW'(1);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (own_last) begin
            col_in = '0;
            row_in = has_own ? '0 : row_ff + p5r_pkg::IDX_W'(1);
         end else begin
            col_in = col_idx + p5r_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= accept;
      end
   end

   // buffers read before they are written; the older row moves down in the cycle after the read
   always_ff @(posedge clock) begin
      if (accept) begin
         center_ff         <= u_above_mem[addr];
         right_ff          <= u_above_mem[addr_right];
         up2_ff            <= u_two_mem[addr];
         f_ff              <= f_above_mem[addr];
         u_above_mem[addr] <= u_value;
         f_above_mem[addr] <= f_value;
         u_ff              <= u_value;
         wb_addr_ff        <= addr;
         meta_ff           <= '{has_above, interior, has_own, own_last,
                                col_idx, row_above, row_ff};
      end
      if (valid_ff) begin
         u_two_mem[wb_addr_ff] <= center_ff;
      end
   end

   assign work_valid = valid_ff;
   assign work = '{meta_ff, u_ff, f_ff, center_ff, right_ff, up2_ff};
endmodule

>>> hw/rtl/p5r_back.sv
// ----------------------------------------------------------------------------
// p5r_back
// Stencil arithmetic: differences, split coefficient products, rounding,
// saturation and result packing.
// ----------------------------------------------------------------------------
module p5r_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             work_valid,
   input  p5r_pkg::work_type                work,
   input  logic [p5r_pkg::COEF_W-1:0]       coef_x,
   input  logic [p5r_pkg::COEF_W-1:0]       coef_y,
   output p5r_pkg::push_type                push
);
   localparam int VW = p5r_pkg::VALUE_W;
   localparam int DW = VW + 2;
   localparam int PW = DW + p5r_pkg::COEF_HALF + 1;
   localparam int SW = PW + 1;
   localparam int TW = SW + (p5r_pkg::FRAC_BITS - p5r_pkg::COEF_FRAC) + 1;
   localparam int RW = TW + 1;

   logic signed [VW-1:0] left_ff;

   logic                 v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   p5r_pkg::meta_type    m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [VW-1:0] f2_ff, f3_ff, f4_ff, f5_ff;
   logic signed [DW-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic signed [PW-1:0] pxh_ff, pyh_ff, pxl_ff, pyl_ff;
   logic signed [SW-1:0] a_ff, b_ff, b_round;
   logic signed [TW-1:0] t_in, t_ff;
   logic signed [RW-1:0] r_full;
   logic signed [VW-1:0] r_clip;
   logic                 r_sat;
   p5r_pkg::push_type    push_in, push_ff;
   p5r_pkg::rsp_type     res_above, res_own;

   logic signed [p5r_pkg::COEF_HALF:0] cxh, cxl, cyh, cyl;

   assign cxh = {1'b0, coef_x[p5r_pkg::COEF_W-1:p5r_pkg::COEF_HALF]};
   assign cxl = {1'b0, coef_x[p5r_pkg::COEF_HALF-1:0]};
   assign cyh = {1'b0, coef_y[p5r_pkg::COEF_W-1:p5r_pkg::COEF_HALF]};
   assign cyl = {1'b0, coef_y[p5r_pkg::COEF_HALF-1:0]};

   // left neighbor is the center of the previous beat of the same row
   assign dx_in = DW'(left_ff) - (DW'(work.center) <<< 1) + DW'(work.right);
   assign dy_in = DW'(work.up2) - (DW'(work.center) <<< 1) + DW'(work.u_value);

   assign b_round = b_ff + (SW'(1) <<< (p5r_pkg::COEF_FRAC - 1));
   assign t_in    = (TW'(a_ff) <<< (p5r_pkg::FRAC_BITS - p5r_pkg::COEF_FRAC))
                    + TW'(b_round >>> p5r_pkg::COEF_FRAC);

   always_comb begin
      r_full = RW'(f5_ff) - RW'(t_ff);
      r_sat  = !((&r_full[RW-1:VW-1]) || !(|r_full[RW-1:VW-1]));
      if (r_sat) r_clip = r_full[RW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      else       r_clip = r_full[VW-1:0];

      res_above.residual  = m5_ff.interior ? r_clip : '0;
      res_above.saturated = m5_ff.interior && r_sat;
      res_above.x_index   = m5_ff.x_index;
      res_above.y_index   = m5_ff.y_above;
      res_above.last      = 1'b0;
      res_own.residual    = '0;
      res_own.saturated   = 1'b0;
      res_own.x_index     = m5_ff.x_index;
      res_own.y_index     = m5_ff.y_cur;
      res_own.last        = m5_ff.own_last;

      push_in.first  = v5_ff && (m5_ff.has_above || m5_ff.has_own);
      push_in.second = v5_ff && m5_ff.has_above && m5_ff.has_own;
      push_in.entry0 = m5_ff.has_above ? res_above : res_own;
      push_in.entry1 = res_own;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v2_ff <= work_valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= push_in.first;
      end
   end

   always_ff @(posedge clock) begin
      if (work_valid) begin
         left_ff <= work.center;
      end
      m2_ff  <= work.meta;
      f2_ff  <= work.f_above;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      m3_ff  <= m2_ff;
      f3_ff  <= f2_ff;
      pxh_ff <= PW'(cxh) * PW'(dx_ff);
      pyh_ff <= PW'(cyh) * PW'(dy_ff);
      pxl_ff <= PW'(cxl) * PW'(dx_ff);
      pyl_ff <= PW'(cyl) * PW'(dy_ff);
      m4_ff  <= m3_ff;
      f4_ff  <= f3_ff;
      a_ff   <= SW'(pxh_ff) + SW'(pyh_ff);
      b_ff   <= SW'(pxl_ff) + SW'(pyl_ff);
      m5_ff  <= m4_ff;
      f5_ff  <= f4_ff;
      t_ff   <= t_in;
      push_ff <= push_in;
   end

   always_comb begin
      push        = push_ff;
      push.first  = v6_ff && push_ff.first;
      push.second = v6_ff && push_ff.second;
   end
endmodule

>>> hw/rtl/p5r_queue.sv
// ----------------------------------------------------------------------------
// p5r_queue
// Result queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module p5r_queue (
   input  logic              clock,
   input  logic              reset,
   input  p5r_pkg::push_type push,
   input  logic              pop,
   output logic              not_empty,
   output p5r_pkg::rsp_type  head
);
   localparam int PTR_W = $clog2(p5r_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(p5r_pkg::FIFO_DEPTH + 1);

   p5r_pkg::rsp_type  entries_ff [p5r_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_pop;

   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign head      = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push.first) + PTR_W'(push.second);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(do_pop);
         count_ff  <= count_ff + CNT_W'(push.first) + CNT_W'(push.second)
                      - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entries_ff[wr_ptr_ff] <= push.entry0;
      end
      if (push.second) begin
         entries_ff[wr_ptr_ff + PTR_W'(1)] <= push.entry1;
      end
   end
endmodule

>>> hw/rtl/poisson_five_point_residual.sv
// Path: front registers, then difference, product, sum, term and push registers, then the
// result queue. Throughput: one grid point per cycle; the last row sends two residuals per
// point and drains at one per cycle while rsp_bus.ready is high. Input is held off only
// when the 16-entry result queue, counting results in the pipe, could not take two more.
// Reset clears the counters, the queue and the registers (coefficients 0, panels 40);
// the line buffers are not cleared.
// ----------------------------------------------------------------------------
// poisson_five_point_residual
// Streams a raster grid and returns the five-point Laplacian residual per point.
// ----------------------------------------------------------------------------
module poisson_five_point_residual (
   input  logic                                clock,
   input  logic                                reset,
   p5r_req_if.sink                             req_bus,
   p5r_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [p5r_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [p5r_pkg::COEF_W-1:0]          csr_write_data
);
   localparam int CW = $clog2(p5r_pkg::FIFO_DEPTH + 1);

   logic [p5r_pkg::COEF_W-1:0] coef_x_ff, coef_y_ff;
   logic [p5r_pkg::IDX_W-1:0]  x_panels_ff, y_panels_ff;
   logic [CW-1:0]              reserved_ff, reserved_in;
   logic                       accept, pop, not_empty;
   logic [1:0]                 n_results;
   logic                       work_valid;
   p5r_pkg::work_type          work;
   p5r_pkg::push_type          push;
   p5r_pkg::rsp_type           head;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_ff   <= p5r_pkg::COEF_RESET;
         coef_y_ff   <= p5r_pkg::COEF_RESET;
         x_panels_ff <= p5r_pkg::PANELS_RESET;
         y_panels_ff <= p5r_pkg::PANELS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            p5r_pkg::CSR_COEF_X:   coef_x_ff   <= csr_write_data;
            p5r_pkg::CSR_COEF_Y:   coef_y_ff   <= csr_write_data;
            p5r_pkg::CSR_X_PANELS: x_panels_ff <= csr_write_data[p5r_pkg::IDX_W-1:0];
            p5r_pkg::CSR_Y_PANELS: y_panels_ff <= csr_write_data[p5r_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // queue slots spoken for by beats still in flight
   assign req_bus.ready = (reserved_ff <= CW'(p5r_pkg::FIFO_DEPTH - 2));
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.ready && not_empty;
   assign reserved_in   = reserved_ff + (accept ? CW'(n_results) : '0) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) reserved_ff <= '0;
      else       reserved_ff <= reserved_in;
   end

   p5r_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .u_value    (req_bus.u_value),
      .f_value    (req_bus.f_value),
      .x_panels   (x_panels_ff),
      .y_panels   (y_panels_ff),
      .n_results  (n_results),
      .work_valid (work_valid),
      .work       (work)
   );

   p5r_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work       (work),
      .coef_x     (coef_x_ff),
      .coef_y     (coef_y_ff),
      .push       (push)
   );

   p5r_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   assign rsp_bus.valid     = not_empty;
   assign rsp_bus.residual  = head.residual;
   assign rsp_bus.x_index   = head.x_index;
   assign rsp_bus.y_index   = head.y_index;
   assign rsp_bus.saturated = head.saturated;
   assign rsp_bus.last      = head.last;
endmodule

>>> hw/rtl/p5r_checker.sv
// ----------------------------------------------------------------------------
// p5r_checker
// Port-level checks of the residual stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "poisson_five_point_residual_macros.svh"

module p5r_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [p5r_pkg::VALUE_W-1:0] residual,
   input logic                               saturated,
   input logic                               last
);
   localparam logic signed [p5r_pkg::VALUE_W-1:0] POS_RAIL =
      {1'b0, {(p5r_pkg::VALUE_W-1){1'b1}}};
   localparam logic signed [p5r_pkg::VALUE_W-1:0] NEG_RAIL =
      {1'b1, {(p5r_pkg::VALUE_W-1){1'b0}}};

   `P5R_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `P5R_ASSERT_IMP(a_last_zero, clock, reset, rsp_valid && last, residual == '0 && !saturated)
   `P5R_ASSERT_IMP(a_sat_clip, clock, reset, rsp_valid && saturated, residual == POS_RAIL || residual == NEG_RAIL)
   `P5R_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
endmodule

bind poisson_five_point_residual p5r_checker u_p5r_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .residual  (rsp_bus.residual),
   .saturated (rsp_bus.saturated),
   .last      (rsp_bus.last)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Five-point residual testbench
// Streams whole grids through the residual block under random source gaps and
// sink stalls. A scoreboard predicts every residual beat from its own line
// buffers and checks the result stream in order.
// ----------------------------------------------------------------------------
module tb;
   typedef logic signed [79:0] acc_type;

   localparam int MAX_PTS     = p5r_pkg::MAX_PANELS;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PTS  = 800;

   class residual_scoreboard;
      logic signed [p5r_pkg::VALUE_W-1:0] u_up[0:MAX_PTS];
      logic signed [p5r_pkg::VALUE_W-1:0] u_up2[0:MAX_PTS];
      logic signed [p5r_pkg::VALUE_W-1:0] f_up[0:MAX_PTS];
      logic [p5r_pkg::COEF_W-1:0]         cx, cy;
      logic [p5r_pkg::IDX_W-1:0]          xreg, yreg;
      int                                 col, row;
      int                                 errors;
      p5r_pkg::rsp_type                   pending_q[$];

      function new();
         cx = p5r_pkg::COEF_RESET;
         cy = p5r_pkg::COEF_RESET;
         xreg = p5r_pkg::PANELS_RESET;
         yreg = p5r_pkg::PANELS_RESET;
         col = 0;
         row = 0;
         errors = 0;
      endfunction

      function int clamp(logic [p5r_pkg::IDX_W-1:0] v);
         if (v < p5r_pkg::PANELS_MIN) return p5r_pkg::PANELS_MIN;
         if (v > MAX_PTS) return MAX_PTS;
         return v;
      endfunction

      function void write_reg(logic [p5r_pkg::CSR_IDX_W-1:0] idx,
                              logic [p5r_pkg::COEF_W-1:0] d);
         case (idx)
            p5r_pkg::CSR_COEF_X:   cx = d;
            p5r_pkg::CSR_COEF_Y:   cy = d;
            p5r_pkg::CSR_X_PANELS: xreg = d[p5r_pkg::IDX_W-1:0];
            p5r_pkg::CSR_Y_PANELS: yreg = d[p5r_pkg::IDX_W-1:0];
            default: ;
         endcase
      endfunction

      function p5r_pkg::rsp_type mk(logic signed [p5r_pkg::VALUE_W-1:0] r, int x, int y,
                                    bit s, bit l);
         p5r_pkg::rsp_type e;
         e.residual = r;
         e.x_index = p5r_pkg::IDX_W'(x);
         e.y_index = p5r_pkg::IDX_W'(y);
         e.saturated = s;
         e.last = l;
         return e;
      endfunction

      function void expect_beat(p5r_pkg::rsp_type e);
         pending_q.insert(pending_q.size(), e);
      endfunction

      // one accepted grid point: residual of the point above, plus own zero on last row
      function void note_point(logic signed [p5r_pkg::VALUE_W-1:0] u,
                               logic signed [p5r_pkg::VALUE_W-1:0] f);
         int      xp, yp, i, j;
         acc_type c, dx, dy, s, t, r;
         bit      sat;
         xp = clamp(xreg);
         yp = clamp(yreg);
         i = (col > MAX_PTS) ? MAX_PTS : col;
         j = row;
         if (j >= 1) begin
            r = 0;
            sat = 0;
            if (j - 1 >= 1 && j - 1 < yp && i >= 1 && i < xp) begin
               c = acc_type'(u_up[i]);
               dx = acc_type'(u_up2[i-1]) - 2 * c + acc_type'(u_up[i+1]);
               dy = acc_type'(u_up2[i]) - 2 * c + acc_type'(u);
               s = acc_type'({1'b0, cx}) * dx + acc_type'({1'b0, cy}) * dy;
               t = (s + 2048) >>> p5r_pkg::COEF_FRAC;
               r = acc_type'(f_up[i]) - t;
               if (r > acc_type'(32'sh7fffffff)) begin
                  r = acc_type'(32'sh7fffffff);
                  sat = 1;
               end else if (r < acc_type'(-33'sd2147483648)) begin
                  r = acc_type'(-33'sd2147483648);
                  sat = 1;
               end
            end
            expect_beat(mk(r[31:0], i, j - 1, sat, 0));
         end
         u_up2[i] = u_up[i];
         u_up[i] = u;
         f_up[i] = f;
         if (j >= yp) expect_beat(mk(0, i, j, 0, i >= xp));
         if (i >= xp) begin
            col = 0;
            row = (j >= yp) ? 0 : j + 1;
         end else begin
            col = i + 1;
         end
      endfunction

      function void check_result(p5r_pkg::rsp_type got);
         p5r_pkg::rsp_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected residual beat %p", $time, got);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (got.residual !== e.residual) begin
            $display("%0t: residual exp %h got %h", $time, e.residual, got.residual);
            errors++;
         end
         if (got.x_index !== e.x_index) begin
            $display("%0t: x_index exp %0d got %0d", $time, e.x_index, got.x_index);
            errors++;
         end
         if (got.y_index !== e.y_index) begin
            $display("%0t: y_index exp %0d got %0d", $time, e.y_index, got.y_index);
            errors++;
         end
         if (got.saturated !== e.saturated) begin
            $display("%0t: saturated exp %b got %b", $time, e.saturated, got.saturated);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           csr_write_enable = 0;
   logic [p5r_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [p5r_pkg::COEF_W-1:0]     csr_write_data = '0;
   int                             cycles = 0;
   int                             sent = 0;
   bit                             src_quiet = 0;
   bit                             snk_quiet = 0;
   residual_scoreboard             sb = new();

   p5r_req_if req_bus();
   p5r_rsp_if rsp_bus();

   poisson_five_point_residual dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** poisson_five_point_residual: FAILED **");
         $finish;
      end
   end

   // monitor: both channels sampled at the edge that completes the beat
   always @(posedge clock) begin
      p5r_pkg::rsp_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_point(req_bus.u_value, req_bus.f_value);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.residual = rsp_bus.residual;
            got.x_index = rsp_bus.x_index;
            got.y_index = rsp_bus.y_index;
            got.saturated = rsp_bus.saturated;
            got.last = rsp_bus.last;
            sb.check_result(got);
         end
      end
   end

   // sink: random stalls with quiet stretches
   initial begin
      int n;
      rsp_bus.ready = 0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0) snk_quiet = ~snk_quiet;
         n = snk_quiet ? 0 : $urandom_range(0, 12);
         if (n > 0) begin
            rsp_bus.ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   function logic [31:0] pick_value(int mode);
      case (mode)
         0: return $urandom_range(0, 32'h200000) - 32'h100000;
         1: return $urandom;
         default:
            case ($urandom_range(0, 4))
               0: return 32'h80000000;
               1: return 32'h7fffffff;
               2: return 32'h0;
               3: return 32'hffffffff;
               default: return $urandom;
            endcase
      endcase
   endfunction

   task automatic send_point(logic [31:0] u, logic [31:0] f);
      int gap;
      if ($urandom_range(0, 29) == 0) src_quiet = ~src_quiet;
      gap = src_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.u_value <= u;
      req_bus.f_value <= f;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      do @(posedge clock); while (sb.pending_q.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [p5r_pkg::CSR_IDX_W-1:0] idx,
                            logic [p5r_pkg::COEF_W-1:0] d);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
   endtask

   // full grid; hold_at >= 0 pauses the source there until all results are back
   task automatic run_grid(logic [31:0] cx, logic [31:0] cy, logic [31:0] xr,
                           logic [31:0] yr, int mode, int hold_at);
      int pts;
      drain();
      write_csr(p5r_pkg::CSR_COEF_X, cx);
      write_csr(p5r_pkg::CSR_COEF_Y, cy);
      write_csr(p5r_pkg::CSR_X_PANELS, xr);
      write_csr(p5r_pkg::CSR_Y_PANELS, yr);
      csr_write_enable <= 0;
      pts = (sb.clamp(sb.xreg) + 1) * (sb.clamp(sb.yreg) + 1);
      for (int k = 0; k < pts; k++) begin
         if (k == hold_at) drain();
         send_point(pick_value(mode), pick_value(mode));
      end
   endtask

   initial begin
      int rp;
      logic [31:0] cx, cy;
      req_bus.valid = 0;
      req_bus.u_value = '0;
      req_bus.f_value = '0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: unit coefficients, saturating coefficients, clamped panel counts
      run_grid(32'h1000, 32'h1000, 2, 2, 2, -1);
      run_grid(32'hffffffff, 32'hffffffff, 2, 2, 2, -1);
      run_grid(32'h2000, 32'h0, 0, 1, 0, -1);

      rp = sent;
      while (sent - rp < RANDOM_PTS) begin
         case ($urandom_range(0, 3))
            0: cx = $urandom;
            1: cx = 0;
            default: cx = $urandom_range(0, 32'h10000);
         endcase
         case ($urandom_range(0, 3))
            0: cy = $urandom;
            1: cy = 0;
            default: cy = $urandom_range(0, 32'h10000);
         endcase
         run_grid(cx, cy, $urandom_range(2, 12), $urandom_range(2, 10),
                  ($urandom_range(0, 3) == 0) ? 1 : 0,
                  (sent - rp < 60) ? $urandom_range(3, 20) : -1);
      end

      drain();
      if (sb.errors == 0) begin
         $display("** poisson_five_point_residual: PASSED **");
      end else begin
         $display("** poisson_five_point_residual: FAILED **");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/p5r_pkg.sv
hw/rtl/p5r_if.sv
hw/rtl/p5r_front.sv
hw/rtl/p5r_back.sv
hw/rtl/p5r_queue.sv
hw/rtl/poisson_five_point_residual.sv
hw/rtl/p5r_checker.sv
tb/tb.sv
